FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file bgoe_checker.sv.
// Pulled in by `include from bgoe_checker.sv; nothing else in the project depends on it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, reset masks the check.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/bgoe_pkg.sv
// Package of the glyph outline emitter: field widths, codes, queue entry and config types.
// No dependencies; every other file of the block but assert_macros.svh uses it.
`default_nettype none

package bgoe_pkg;

   localparam int ROW_W       = 64;
   localparam int ROW_IDX_W   = 6;
   localparam int DIM_W       = 7;
   localparam int COORD_W     = 16;
   localparam int PROD_W      = 13;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int NUM_SLOTS   = 7;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_SCAN  = 1'b1;
   localparam logic KIND_LINE  = 1'b0;
   localparam logic KIND_POINT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_SIZE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH_HEIGHT = 3'd4;

   // Command slots of one cell, in emission order.
   typedef enum logic [2:0] {
      SLOT_LEFT,
      SLOT_RIGHT,
      SLOT_TOP,
      SLOT_BOTTOM,
      SLOT_VERT,
      SLOT_HORZ,
      SLOT_CORNER
   } slot_type;

   typedef struct packed {
      logic [COORD_W-1:0] origin_x;
      logic [COORD_W-1:0] origin_y;
      logic [DIM_W-1:0]   pixel_size;
      logic [DIM_W-1:0]   glyph_width;
      logic [DIM_W-1:0]   glyph_height;
   } cfg_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0] slots;
      logic                 dot_a;
      logic                 corner_x_inc;
      logic                 corner_y_inc;
      logic [PROD_W-1:0]    p_col;
      logic [PROD_W-1:0]    p_row;
      logic [PROD_W-1:0]    p_width;
      logic [PROD_W-1:0]    p_height;
   } cell_entry_type;

   typedef struct packed {
      logic              not_empty;
      logic [QCNT_W-1:0] free;
   } q_status_type;

endpackage

`default_nettype wire

FILE: hdl/bgoe_req_if.sv
// Input channel of the glyph outline emitter: row loads and cell scans.
// Depends on bgoe_pkg for field widths.
`default_nettype none

interface bgoe_req_if;
   logic                              valid;
   logic                              ready;
   logic                              mode;
   logic [bgoe_pkg::ROW_IDX_W-1:0]    row_index;
   logic [bgoe_pkg::ROW_IDX_W-1:0]    column_index;
   logic [bgoe_pkg::ROW_W-1:0]        row_bits;

   modport source (output valid, mode, row_index, column_index, row_bits, input ready);
   modport sink   (input valid, mode, row_index, column_index, row_bits, output ready);
endinterface

`default_nettype wire

FILE: hdl/bgoe_rsp_if.sv
// Result channel of the glyph outline emitter: draw commands.
// Depends on bgoe_pkg for field widths.
`default_nettype none

interface bgoe_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                command_kind;
   logic signed [bgoe_pkg::COORD_W-1:0] x_start;
   logic signed [bgoe_pkg::COORD_W-1:0] y_start;
   logic signed [bgoe_pkg::COORD_W-1:0] x_end;
   logic signed [bgoe_pkg::COORD_W-1:0] y_end;
   logic                                last_of_cell;

   modport source (output valid, command_kind, x_start, y_start, x_end, y_end,
                   last_of_cell, input ready);
   modport sink   (input valid, command_kind, x_start, y_start, x_end, y_end,
                   last_of_cell, output ready);
endinterface

`default_nettype wire

FILE: hdl/bgoe_csr_if.sv
// Register write channel of the glyph outline emitter.
// Depends on bgoe_pkg for index and data widths.
`default_nettype none

interface bgoe_csr_if;
   logic                              valid;
   logic                              ready;
   logic [bgoe_pkg::CSR_IDX_W-1:0]    index;
   logic [bgoe_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/bgoe_front.sv
// Front end: glyph row store, row reads for a scan and cell classification.
// Depends on bgoe_pkg and bgoe_req_if; pushes cell entries into bgoe_queue.
`default_nettype none

module bgoe_front #(
   parameter int MAX_GLYPH_DIM = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   bgoe_req_if.sink                      req_ch,
   input  wire bgoe_pkg::cfg_type        cfg,
   input  wire bgoe_pkg::q_status_type   q_status,
   output logic                          push_valid,
   output bgoe_pkg::cell_entry_type      push_entry
);

   localparam int AW = $clog2(MAX_GLYPH_DIM);
   localparam logic [bgoe_pkg::DIM_W-1:0] DIM_LIMIT = bgoe_pkg::DIM_W'(MAX_GLYPH_DIM);

   logic [bgoe_pkg::ROW_W-1:0] glyph_rows_mem [MAX_GLYPH_DIM];

   logic                             s1_valid_ff;
   logic [bgoe_pkg::ROW_IDX_W-1:0]   s1_row_ff;
   logic [bgoe_pkg::ROW_IDX_W-1:0]   s1_col_ff;
   logic [bgoe_pkg::ROW_W-1:0]       row_top_ff;
   logic [bgoe_pkg::ROW_W-1:0]       row_bot_ff;

   logic                             accept;
   logic [bgoe_pkg::DIM_W-1:0]       req_row7;
   logic [bgoe_pkg::DIM_W-1:0]       req_below7;
   logic [bgoe_pkg::DIM_W-1:0]       width_c;
   logic [bgoe_pkg::DIM_W-1:0]       height_c;
   logic [bgoe_pkg::DIM_W-1:0]       row7;
   logic [bgoe_pkg::DIM_W-1:0]       col7;
   logic [bgoe_pkg::DIM_W-1:0]       row_next7;
   logic [bgoe_pkg::DIM_W-1:0]       col_next7;
   logic [bgoe_pkg::ROW_W-1:0]       top_shift;
   logic [bgoe_pkg::ROW_W-1:0]       bot_shift;
   logic                             dot_a, dot_b, dot_c, dot_d;
   logic                             in_glyph, has_right, has_below;
   logic [bgoe_pkg::NUM_SLOTS-1:0]   slots;

   // One scan in flight here; take an item only while the queue keeps a slot for it.
   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = q_status.free > bgoe_pkg::QCNT_W'(s1_valid_ff);

   assign req_row7   = {1'b0, req_ch.row_index};
   assign req_below7 = req_row7 + bgoe_pkg::DIM_W'(1);

   always_ff @(posedge clock) begin
      if (accept && req_ch.mode == bgoe_pkg::MODE_LOAD && req_row7 < DIM_LIMIT) begin
         glyph_rows_mem[req_ch.row_index[AW-1:0]] <= req_ch.row_bits;
      end
      row_top_ff <= glyph_rows_mem[req_row7[AW-1:0]];
      row_bot_ff <= glyph_rows_mem[req_below7[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept && req_ch.mode == bgoe_pkg::MODE_SCAN;
      end
      if (accept) begin
         s1_row_ff <= req_ch.row_index;
         s1_col_ff <= req_ch.column_index;
      end
   end

   always_comb begin
      width_c   = (cfg.glyph_width  > DIM_LIMIT) ? DIM_LIMIT : cfg.glyph_width;
      height_c  = (cfg.glyph_height > DIM_LIMIT) ? DIM_LIMIT : cfg.glyph_height;
      row7      = {1'b0, s1_row_ff};
      col7      = {1'b0, s1_col_ff};
      row_next7 = row7 + bgoe_pkg::DIM_W'(1);
      col_next7 = col7 + bgoe_pkg::DIM_W'(1);

      top_shift = row_top_ff >> s1_col_ff;
      bot_shift = row_bot_ff >> s1_col_ff;
      dot_a     = top_shift[0];
      dot_c     = top_shift[1];
      dot_b     = bot_shift[0];
      dot_d     = bot_shift[1];

      in_glyph  = (row7 < height_c) && (col7 < width_c);
      has_right = col_next7 < width_c;
      has_below = row_next7 < height_c;

      slots                        = '0;
      slots[bgoe_pkg::SLOT_LEFT]   = (col7 == '0) && dot_a;
      slots[bgoe_pkg::SLOT_RIGHT]  = (col_next7 == width_c) && dot_a;
      slots[bgoe_pkg::SLOT_TOP]    = (row7 == '0) && dot_a;
      slots[bgoe_pkg::SLOT_BOTTOM] = (row_next7 == height_c) && dot_a;
      slots[bgoe_pkg::SLOT_VERT]   = has_right && (dot_a ^ dot_c);
      slots[bgoe_pkg::SLOT_HORZ]   = has_below && (dot_a ^ dot_b);
      // exactly one of the four dots around the lower right corner is blank
      slots[bgoe_pkg::SLOT_CORNER] = has_right && has_below &&
                                     (( dot_a &&  dot_b &&  dot_c && !dot_d) ||
                                      (!dot_a &&  dot_b &&  dot_c &&  dot_d) ||
                                      ( dot_a && !dot_b &&  dot_c &&  dot_d) ||
                                      ( dot_a &&  dot_b && !dot_c &&  dot_d));

      push_entry.slots        = slots;
      push_entry.dot_a        = dot_a;
      push_entry.corner_x_inc = !dot_a || !dot_b;
      push_entry.corner_y_inc = !dot_a || !dot_c;
      push_entry.p_col    = bgoe_pkg::PROD_W'(cfg.pixel_size) * bgoe_pkg::PROD_W'(s1_col_ff);
      push_entry.p_row    = bgoe_pkg::PROD_W'(cfg.pixel_size) * bgoe_pkg::PROD_W'(s1_row_ff);
      push_entry.p_width  = bgoe_pkg::PROD_W'(cfg.pixel_size) * bgoe_pkg::PROD_W'(width_c);
      push_entry.p_height = bgoe_pkg::PROD_W'(cfg.pixel_size) * bgoe_pkg::PROD_W'(height_c);

      // drop cells outside the glyph and cells with nothing to draw
      push_valid = s1_valid_ff && in_glyph && (slots != '0);
   end

endmodule

`default_nettype wire

FILE: hdl/bgoe_queue.sv
// Short queue of classified cells between front and back end.
// Depends on bgoe_pkg for the entry type and depth constants.
`default_nettype none

module bgoe_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push_valid,
   input  wire bgoe_pkg::cell_entry_type push_entry,
   input  wire logic                     pop,
   output bgoe_pkg::cell_entry_type      head_entry,
   output bgoe_pkg::q_status_type        q_status
);

   bgoe_pkg::cell_entry_type entries_ff [bgoe_pkg::QUEUE_DEPTH];

   logic [bgoe_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bgoe_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bgoe_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_pop;

   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = push_valid ? wr_ptr_ff + bgoe_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + bgoe_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + bgoe_pkg::QCNT_W'(push_valid) - bgoe_pkg::QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry         = entries_ff[rd_ptr_ff];
   assign q_status.not_empty = count_ff != '0;
   assign q_status.free      = bgoe_pkg::QCNT_W'(bgoe_pkg::QUEUE_DEPTH) - count_ff;

endmodule

`default_nettype wire

FILE: hdl/bgoe_back.sv
// Back end: turns one queued cell into its draw commands, one beat per cycle unless rsp_ch stalls.
// Depends on bgoe_pkg and bgoe_rsp_if; pops cells from bgoe_queue.
`default_nettype none

module bgoe_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire bgoe_pkg::cfg_type        cfg,
   input  wire bgoe_pkg::q_status_type   q_status,
   input  wire bgoe_pkg::cell_entry_type head_entry,
   output logic                          pop,
   bgoe_rsp_if.source                    rsp_ch
);

   localparam int CW = bgoe_pkg::COORD_W;

   logic [bgoe_pkg::NUM_SLOTS-1:0] slots_ff, slots_in;
   logic                           dot_a_ff, cx_inc_ff, cy_inc_ff;
   logic [CW-1:0]                  x0_ff, x1_ff, y0_ff, y1_ff, xr_ff, yb_ff;
   logic [CW-1:0]                  x0_in, x1_in, y0_in, y1_in, xr_in, yb_in;

   logic                           rsp_valid_ff;
   logic                           kind_ff, kind_in;
   logic [CW-1:0]                  xs_ff, ys_ff, xe_ff, ye_ff;
   logic [CW-1:0]                  xs_in, ys_in, xe_in, ye_in;
   logic                           last_ff;

   logic                           emit;
   bgoe_pkg::slot_type             sel;
   logic [CW-1:0]                  x1p, y1p, xv, yh;

   // Coordinates of a new cell, wrapped to 16 bits.
   always_comb begin
      x0_in = cfg.origin_x + CW'(head_entry.p_col);
      x1_in = cfg.origin_x + CW'(head_entry.p_col) + CW'(cfg.pixel_size) - CW'(1);
      y0_in = cfg.origin_y + CW'(head_entry.p_row);
      y1_in = cfg.origin_y + CW'(head_entry.p_row) + CW'(cfg.pixel_size) - CW'(1);
      xr_in = cfg.origin_x + CW'(head_entry.p_width) - CW'(1);
      yb_in = cfg.origin_y + CW'(head_entry.p_height) - CW'(1);
   end

   always_comb begin
      pop  = q_status.not_empty && (slots_ff == '0);
      emit = (slots_ff != '0) && (!rsp_valid_ff || rsp_ch.ready);

      // lowest pending slot goes first
      sel = bgoe_pkg::SLOT_LEFT;
      for (int k = bgoe_pkg::NUM_SLOTS - 1; k >= 0; k--) begin
         if (slots_ff[k]) begin
            sel = bgoe_pkg::slot_type'(3'(k));
         end
      end
      slots_in = pop  ? head_entry.slots :
                 emit ? (slots_ff & (slots_ff - bgoe_pkg::NUM_SLOTS'(1))) : slots_ff;

      x1p = x1_ff + CW'(1);
      y1p = y1_ff + CW'(1);
      xv  = dot_a_ff ? x1_ff : x1p;
      yh  = dot_a_ff ? y1_ff : y1p;

      kind_in = bgoe_pkg::KIND_LINE;
      xs_in   = x0_ff;
      ys_in   = y0_ff;
      xe_in   = x1_ff;
      ye_in   = y1_ff;
      unique case (sel)
         bgoe_pkg::SLOT_LEFT: begin
            xs_in = cfg.origin_x; ys_in = y0_ff; xe_in = cfg.origin_x; ye_in = y1_ff;
         end
         bgoe_pkg::SLOT_RIGHT: begin
            xs_in = xr_ff; ys_in = y0_ff; xe_in = xr_ff; ye_in = y1_ff;
         end
         bgoe_pkg::SLOT_TOP: begin
            xs_in = x0_ff; ys_in = cfg.origin_y; xe_in = x1_ff; ye_in = cfg.origin_y;
         end
         bgoe_pkg::SLOT_BOTTOM: begin
            xs_in = x0_ff; ys_in = yb_ff; xe_in = x1_ff; ye_in = yb_ff;
         end
         bgoe_pkg::SLOT_VERT: begin
            xs_in = xv; ys_in = y0_ff; xe_in = xv; ye_in = y1_ff;
         end
         bgoe_pkg::SLOT_HORZ: begin
            xs_in = x0_ff; ys_in = yh; xe_in = x1_ff; ye_in = yh;
         end
         bgoe_pkg::SLOT_CORNER: begin
            kind_in = bgoe_pkg::KIND_POINT;
            xs_in   = cx_inc_ff ? x1p : x1_ff;
            ys_in   = cy_inc_ff ? y1p : y1_ff;
            xe_in   = xs_in;
            ye_in   = ys_in;
         end
         default: begin
            kind_in = bgoe_pkg::KIND_LINE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slots_ff <= slots_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (pop) begin
         dot_a_ff  <= head_entry.dot_a;
         cx_inc_ff <= head_entry.corner_x_inc;
         cy_inc_ff <= head_entry.corner_y_inc;
         x0_ff     <= x0_in;
         x1_ff     <= x1_in;
         y0_ff     <= y0_in;
         y1_ff     <= y1_in;
         xr_ff     <= xr_in;
         yb_ff     <= yb_in;
      end
      if (emit) begin
         kind_ff <= kind_in;
         xs_ff   <= xs_in;
         ys_ff   <= ys_in;
         xe_ff   <= xe_in;
         ye_ff   <= ye_in;
         last_ff <= (slots_ff & (slots_ff - bgoe_pkg::NUM_SLOTS'(1))) == '0;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.command_kind = kind_ff;
   assign rsp_ch.x_start      = xs_ff;
   assign rsp_ch.y_start      = ys_ff;
   assign rsp_ch.x_end        = xe_ff;
   assign rsp_ch.y_end        = ye_ff;
   assign rsp_ch.last_of_cell = last_ff;

endmodule

`default_nettype wire

FILE: hdl/bitmap_glyph_outline_emitter_unit.sv
// Top level of the glyph outline emitter: register file, front end, cell queue, back end.
// Depends on bgoe_pkg, the three channel interfaces, bgoe_front, bgoe_queue, bgoe_back.
//
//   channel  dir  modport  beat carries
//   req_ch   in   sink     mode, row_index, column_index, row_bits
//   rsp_ch   out  source   command_kind, x_start, y_start, x_end, y_end, last_of_cell
//   csr_ch   in   sink     index, data (always ready)
//
// A scan beat reads its two rows on the edge that takes it; the cell is then classified,
// pushed into the queue, popped by the back end, and its command reaches the output register.
// The back end emits one command per cycle while rsp_ch is ready and fetches a drawn cell
// only once the previous cell has no command left; that loop sets the sustained rate.
// The front end takes a beat per cycle while the four-entry cell queue has room.
// Reset is synchronous: it empties the pipeline and queue and restores register defaults;
// glyph rows hold garbage until loaded. A stalled rsp_ch holds its beat and backs up
// through the queue into req_ch.ready.
`default_nettype none

module bitmap_glyph_outline_emitter_unit #(
   parameter int MAX_GLYPH_DIM = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bgoe_req_if.sink   req_ch,
   bgoe_rsp_if.source rsp_ch,
   bgoe_csr_if.sink   csr_ch
);

   // Register file: the user must write it only while the block is idle; the block does not enforce this.
   logic [bgoe_pkg::COORD_W-1:0] origin_x_ff;
   logic [bgoe_pkg::COORD_W-1:0] origin_y_ff;
   logic [bgoe_pkg::DIM_W-1:0]   pixel_size_ff;
   logic [bgoe_pkg::DIM_W-1:0]   glyph_width_ff;
   logic [bgoe_pkg::DIM_W-1:0]   glyph_height_ff;

   bgoe_pkg::cfg_type        cfg;
   bgoe_pkg::q_status_type   q_status;
   bgoe_pkg::cell_entry_type push_entry;
   bgoe_pkg::cell_entry_type head_entry;
   logic                     push_valid;
   logic                     pop;

   assign csr_ch.ready = 1'b1;

   // Decode the write index; drop writes past the last register.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
         pixel_size_ff   <= bgoe_pkg::DIM_W'(1);
         glyph_width_ff  <= bgoe_pkg::DIM_W'(8);
         glyph_height_ff <= bgoe_pkg::DIM_W'(8);
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            bgoe_pkg::CSR_ORIGIN_X:     origin_x_ff     <= csr_ch.data;
            bgoe_pkg::CSR_ORIGIN_Y:     origin_y_ff     <= csr_ch.data;
            bgoe_pkg::CSR_PIXEL_SIZE:   pixel_size_ff   <= csr_ch.data[bgoe_pkg::DIM_W-1:0];
            bgoe_pkg::CSR_GLYPH_WIDTH:  glyph_width_ff  <= csr_ch.data[bgoe_pkg::DIM_W-1:0];
            bgoe_pkg::CSR_GLYPH_HEIGHT: glyph_height_ff <= csr_ch.data[bgoe_pkg::DIM_W-1:0];
            default: begin
               origin_x_ff <= origin_x_ff;
            end
         endcase
      end
   end

   assign cfg.origin_x     = origin_x_ff;
   assign cfg.origin_y     = origin_y_ff;
   assign cfg.pixel_size   = pixel_size_ff;
   assign cfg.glyph_width  = glyph_width_ff;
   assign cfg.glyph_height = glyph_height_ff;

   // Front: stores rows, reads the cell's row and the one below, classifies the cell.
   bgoe_front #(
      .MAX_GLYPH_DIM (MAX_GLYPH_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .cfg        (cfg),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // Queue: decouples classification from command emission.
   bgoe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   // Back: walks the pending command slots of one cell and drives rsp_ch.
   bgoe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_status   (q_status),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire

FILE: hdl/bgoe_checker.sv
// Port-level checks on the command channel of the glyph outline emitter.
// Depends on assert_macros.svh and bgoe_pkg; bound to bitmap_glyph_outline_emitter_unit.
`default_nettype none
`include "assert_macros.svh"

module bgoe_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic                        command_kind,
   input wire logic [bgoe_pkg::COORD_W-1:0] x_start,
   input wire logic [bgoe_pkg::COORD_W-1:0] y_start,
   input wire logic [bgoe_pkg::COORD_W-1:0] x_end,
   input wire logic [bgoe_pkg::COORD_W-1:0] y_end,
   input wire logic                        last_of_cell
);

   // a stalled beat holds its valid, start point and last flag
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(x_start) && $stable(y_start) && $stable(last_of_cell), "stalled command beat changed")

   // a point has both ends on one spot
   `ASSERT_SAME(a_point_ends, clock, reset, rsp_valid && command_kind == bgoe_pkg::KIND_POINT, x_start == x_end && y_start == y_end, "point command with distinct ends")

   // every outline segment runs along one axis
   `ASSERT_SAME(a_line_axis, clock, reset, rsp_valid && command_kind == bgoe_pkg::KIND_LINE, x_start == x_end || y_start == y_end, "diagonal outline segment")

   // the corner point always closes its cell
   `ASSERT_SAME(a_point_last, clock, reset, rsp_valid && command_kind == bgoe_pkg::KIND_POINT, last_of_cell, "corner point not last of cell")

endmodule

bind bitmap_glyph_outline_emitter_unit bgoe_checker u_bgoe_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .command_kind (rsp_ch.command_kind),
   .x_start      (rsp_ch.x_start),
   .y_start      (rsp_ch.y_start),
   .x_end        (rsp_ch.x_end),
   .y_end        (rsp_ch.y_end),
   .last_of_cell (rsp_ch.last_of_cell)
);

`default_nettype wire
